// ===== sv/touch_wheel_step_counter_defines.svh =====
// Assertion macros for the touch wheel step counter.
`ifndef TOUCH_WHEEL_STEP_COUNTER_DEFINES_SVH
`define TOUCH_WHEEL_STEP_COUNTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TWSC_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("touch wheel step counter: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TWSC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("touch wheel step counter: next-cycle check failed");

`endif

// ===== sv/twsc_pkg.sv =====
`timescale 1ns / 1ps

package twsc_pkg;

  // Keys that the status word carries and the wheel geometry.
  localparam int KEY_COUNT      = 10;
  localparam int WHEEL_SEGMENTS = 8;

  localparam logic [3:0] KEY_ENTER = 4'h8;
  localparam logic [3:0] KEY_SCRY  = 4'h9;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WHEEL_MODE  = 2'd0;
  localparam logic [1:0] CFG_COUNT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SCRY_CLEARS = 2'd2;

  // Wheel modes.
  localparam logic [2:0] MODE_WRAP    = 3'd0;
  localparam logic [2:0] MODE_BOUNDED = 3'd1;
  localparam logic [2:0] MODE_ONEHOT  = 3'd2;
  localparam logic [2:0] MODE_ABS     = 3'd3;
  localparam logic [2:0] MODE_IGNORE  = 3'd4;

  // Direction codes.
  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam logic [1:0] DIR_FORWARD  = 2'd1;
  localparam logic [1:0] DIR_BACKWARD = 2'd2;

  // Button codes.
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_ENTER = 2'd1;
  localparam logic [1:0] BTN_SCRY  = 2'd2;

  typedef struct packed {
    logic [2:0] wheel_mode;
    logic [8:0] count_limit;
    logic       scry_clears;
  } twsc_cfg_t;

  typedef struct packed {
    logic [3:0] current_key;
    logic [2:0] ref_segment;
    logic       ref_valid;
    logic [7:0] step_count;
  } twsc_state_t;

  typedef struct packed {
    logic [3:0] key_index;
    logic [1:0] direction;
    logic [1:0] button;
    logic [7:0] count_value;
    logic [7:0] display_value;
  } twsc_result_t;

endpackage

// ===== sv/twsc_decode.sv =====
`timescale 1ns / 1ps

module twsc_decode (
  input  logic [15:0]          touch_status,
  input  twsc_pkg::twsc_cfg_t   cfg,
  input  twsc_pkg::twsc_state_t state,
  output twsc_pkg::twsc_state_t state_nxt,
  output twsc_pkg::twsc_result_t result
);
  import twsc_pkg::*;

  logic [3:0] key;
  logic [2:0] mode;
  logic [8:0] lim;
  logic [8:0] lim_b;
  logic [2:0] seg_delta;
  logic [1:0] dir;
  logic [1:0] btn;
  logic [7:0] cnt;
  logic [8:0] cnt_inc;

  // Highest set key bit wins; with none set the previous key stands.
  always_comb begin
    key = state.current_key;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (touch_status[i]) begin
        key = 4'(i);
      end
    end
  end

  // Clamp the mode and the limit to their meaningful ranges.
  assign mode  = (cfg.wheel_mode > MODE_IGNORE) ? MODE_IGNORE : cfg.wheel_mode;
  assign lim   = (cfg.count_limit == 9'd0) ? 9'd1 :
                 ((cfg.count_limit > 9'd256) ? 9'd256 : cfg.count_limit);
  assign lim_b = (mode == MODE_ONEHOT && lim > 9'd8) ? 9'd8 : lim;

  // Distance round the wheel from the reference segment.
  assign seg_delta = key[2:0] - state.ref_segment;
  assign cnt_inc   = {1'b0, state.step_count} + 9'd1;

  // Event decode and state update.
  always_comb begin
    dir       = DIR_NONE;
    btn       = BTN_NONE;
    cnt       = state.step_count;
    state_nxt = state;
    state_nxt.current_key = key;
    if (key < 4'(WHEEL_SEGMENTS)) begin
      if (mode <= MODE_ONEHOT) begin
        if (state.ref_valid) begin
          if (seg_delta >= 3'd1 && seg_delta <= 3'd3) begin
            dir = DIR_FORWARD;
          end else if (seg_delta >= 3'd5) begin
            dir = DIR_BACKWARD;
          end
        end
        if (mode == MODE_WRAP) begin
          if (dir == DIR_FORWARD) begin
            cnt = state.step_count + 8'd1;
          end else if (dir == DIR_BACKWARD) begin
            cnt = state.step_count - 8'd1;
          end
        end else begin
          if (dir == DIR_FORWARD && cnt_inc < lim_b) begin
            cnt = cnt_inc[7:0];
          end else if (dir == DIR_BACKWARD && state.step_count != 8'd0) begin
            cnt = state.step_count - 8'd1;
          end
        end
        state_nxt.ref_segment = key[2:0];
        state_nxt.ref_valid   = 1'b1;
      end else if (mode == MODE_ABS) begin
        cnt = 8'd1 << key[2:0];
      end
    end else if (key == KEY_ENTER) begin
      btn = BTN_ENTER;
    end else if (key == KEY_SCRY) begin
      btn = BTN_SCRY;
      if (cfg.scry_clears) begin
        cnt                   = 8'd0;
        state_nxt.ref_segment = 3'd0;
        state_nxt.ref_valid   = 1'b1;
      end
    end
    state_nxt.step_count = cnt;
  end

  // Result assembly; mode 2 shows the counter as a one-hot bar.
  always_comb begin
    result.key_index   = key;
    result.direction   = dir;
    result.button      = btn;
    result.count_value = cnt;
    if (mode == MODE_ONEHOT) begin
      result.display_value = (cnt < 8'd8) ? (8'd1 << cnt[2:0]) : 8'd0;
    end else begin
      result.display_value = cnt;
    end
  end

endmodule

// ===== sv/touch_wheel_step_counter.sv =====
`timescale 1ns / 1ps
// Touch wheel step counter.
// Input channel: one 16-bit key status word per transaction on in_touch_status,
// moved when in_valid is high and in_stall is low. Every input transaction
// yields exactly one result transaction on the out_ ports, moved when
// out_valid is high and out_stall is low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 wheel
// mode, 1 count limit, 2 scry clears) at the clock edge; no read-back.
// The status word lands in an input register, and the decode and counter
// update then run from it into the output register.
// Throughput is one transaction per cycle while out_stall is low; the counter
// and reference update completes as an item moves to the output.
// When the receiver stalls, the result is held and one further item waits
// in the input register; only then is in_stall raised.
// Synchronous active-low reset empties both registers, clears the counter,
// the key and the reference (no reference yet), and loads the register
// defaults: wrap mode, limit 256, scry clears enabled.
module touch_wheel_step_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_touch_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_key_index,
  output logic [1:0]  out_direction,
  output logic [1:0]  out_button,
  output logic [7:0]  out_count_value,
  output logic [7:0]  out_display_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import twsc_pkg::*;
  `include "touch_wheel_step_counter_defines.svh"

  twsc_cfg_t    cfg_r;
  twsc_state_t  state_r;
  twsc_state_t  state_nxt;
  twsc_result_t res_nxt;
  twsc_result_t res_r;
  logic         in_valid_r;
  logic [15:0]  in_status_r;
  logic         out_valid_r;
  logic         advance;

  // The input register moves on whenever the output register is free or
  // is being emptied this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_mode  <= MODE_WRAP;
      cfg_r.count_limit <= 9'd256;
      cfg_r.scry_clears <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEEL_MODE:  cfg_r.wheel_mode  <= cfg_data[2:0];
        CFG_COUNT_LIMIT: cfg_r.count_limit <= cfg_data;
        CFG_SCRY_CLEARS: cfg_r.scry_clears <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_status_r <= in_touch_status;
    end
  end

  twsc_decode u_decode (
    .touch_status (in_status_r),
    .cfg          (cfg_r),
    .state        (state_r),
    .state_nxt    (state_nxt),
    .result       (res_nxt)
  );

  // Wheel state advances only as an item moves to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_index     = res_r.key_index;
  assign out_direction     = res_r.direction;
  assign out_button        = res_r.button;
  assign out_count_value   = res_r.count_value;
  assign out_display_value = res_r.display_value;

  // A waiting item is neither dropped nor taken twice while the output is blocked.
  `TWSC_ASSERT_NEXT(a_in_held, in_valid_r && !advance, in_valid_r && $stable(state_r))
  // Only wheel keys report a direction.
  `TWSC_ASSERT_NOW(a_dir_wheel, out_valid && out_direction != DIR_NONE,
                   out_key_index < 4'(WHEEL_SEGMENTS) && out_button == BTN_NONE)
  // A clearing scry leaves the counter at zero.
  `TWSC_ASSERT_NOW(a_scry_clear, out_valid && out_button == BTN_SCRY && cfg_r.scry_clears,
                   out_count_value == 8'd0)
  // The result register keeps up with the stored counter.
  `TWSC_ASSERT_NOW(a_count_track, out_valid_r && !in_valid_r,
                   out_count_value == state_r.step_count)

endmodule

// ===== tb/touch_wheel_step_counter_test.sv =====
`timescale 1ns / 1ps

module touch_wheel_step_counter_test;
  import twsc_pkg::*;

  // Status bits that name a key, the rest are noise to the block.
  localparam logic [15:0] KEY_MASK = 16'((17'h1 << KEY_COUNT) - 1);
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 60;

  // Predicts every wheel event from the status words that the block accepts,
  // and checks each event that leaves the block against the oldest prediction.
  class wheel_scoreboard;
    twsc_cfg_t    cfg;
    twsc_state_t  st;
    twsc_result_t expected_events[$];
    int           faults;

    function new();
      cfg.wheel_mode  = MODE_WRAP;
      cfg.count_limit = 9'd256;
      cfg.scry_clears = 1'b1;
      st              = '0;
      faults          = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [8:0] data);
      case (index)
        CFG_WHEEL_MODE:  cfg.wheel_mode  = data[2:0];
        CFG_COUNT_LIMIT: cfg.count_limit = data;
        CFG_SCRY_CLEARS: cfg.scry_clears = data[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] bounded_move(logic [7:0] count, logic [1:0] dir, int lim);
      if (dir == DIR_FORWARD && int'(count) + 1 < lim) return count + 8'd1;
      if (dir == DIR_BACKWARD && count > 8'd0) return count - 8'd1;
      return count;
    endfunction

    // Works out the event for one accepted status word.
    function void note_status(logic [15:0] status);
      twsc_result_t ev;
      logic [2:0]   mode;
      logic [2:0]   seg_delta;
      int           lim;
      ev = '0;
      // Highest key bit wins; with none set the previous key stands.
      for (int i = 0; i < KEY_COUNT; i++) begin
        if (status[i]) st.current_key = i[3:0];
      end
      mode = (cfg.wheel_mode > MODE_IGNORE) ? MODE_IGNORE : cfg.wheel_mode;
      lim = int'(cfg.count_limit);
      if (lim == 0) lim = 1;
      if (lim > 256) lim = 256;

      if (st.current_key < WHEEL_SEGMENTS) begin
        if (mode <= MODE_ONEHOT) begin
          if (st.ref_valid) begin
            seg_delta = st.current_key[2:0] - st.ref_segment;
            if (seg_delta >= 3'd1 && seg_delta <= 3'd3) ev.direction = DIR_FORWARD;
            else if (seg_delta >= 3'd5) ev.direction = DIR_BACKWARD;
          end
          case (mode)
            MODE_WRAP: begin
              if (ev.direction == DIR_FORWARD) st.step_count = st.step_count + 8'd1;
              else if (ev.direction == DIR_BACKWARD) st.step_count = st.step_count - 8'd1;
            end
            MODE_BOUNDED: st.step_count = bounded_move(st.step_count, ev.direction, lim);
            default: st.step_count = bounded_move(st.step_count, ev.direction,
                                                  (lim > 8) ? 8 : lim);
          endcase
          st.ref_segment = st.current_key[2:0];
          st.ref_valid   = 1'b1;
        end else if (mode == MODE_ABS) begin
          st.step_count = 8'd1 << st.current_key[2:0];
        end
      end else if (st.current_key == KEY_ENTER) begin
        ev.button = BTN_ENTER;
      end else if (st.current_key == KEY_SCRY) begin
        ev.button = BTN_SCRY;
        if (cfg.scry_clears) begin
          st.step_count  = 8'd0;
          st.ref_segment = 3'd0;
          st.ref_valid   = 1'b1;
        end
      end

      ev.key_index   = st.current_key;
      ev.count_value = st.step_count;
      if (mode == MODE_ONEHOT)
        ev.display_value = (st.step_count < 8'd8) ? (8'd1 << st.step_count[2:0]) : 8'd0;
      else
        ev.display_value = st.step_count;
      expected_events.push_back(ev);
    endfunction

    // Compares one result transaction with the oldest prediction.
    function void check_event(twsc_result_t got);
      twsc_result_t want;
      if (expected_events.size() == 0) begin
        if (faults < 10)
          $display("unexpected result: key %0d dir %0d button %0d count %0d display %0d",
                   got.key_index, got.direction, got.button, got.count_value,
                   got.display_value);
        faults++;
        return;
      end
      want = expected_events.pop_front();
      if (got.key_index !== want.key_index || got.direction !== want.direction ||
          got.button !== want.button || got.count_value !== want.count_value ||
          got.display_value !== want.display_value) begin
        if (faults < 10) begin
          $display("mismatch: expected key %0d dir %0d button %0d count %0d display %0d,",
                   want.key_index, want.direction, want.button, want.count_value,
                   want.display_value);
          $display("          got key %0d dir %0d button %0d count %0d display %0d",
                   got.key_index, got.direction, got.button, got.count_value,
                   got.display_value);
        end
        faults++;
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_touch_status = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_key_index;
  logic [1:0]  out_direction;
  logic [1:0]  out_button;
  logic [7:0]  out_count_value;
  logic [7:0]  out_display_value;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [8:0]  cfg_data = 9'd0;

  wheel_scoreboard sb = new();

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  logic [2:0] sweep_seg = 3'd0;
  bit   sweep_fwd = 1'b1;

  touch_wheel_step_counter i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_touch_status   (in_touch_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_index     (out_key_index),
    .out_direction     (out_direction),
    .out_button        (out_button),
    .out_count_value   (out_count_value),
    .out_display_value (out_display_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: take each result transaction, then choose the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_event({out_key_index, out_direction, out_button, out_count_value,
                      out_display_value});
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one status word and waits until the block takes it.
  task automatic send_status(logic [15:0] status);
    in_valid        <= 1'b1;
    in_touch_status <= status;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_status(status);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] index, logic [8:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  // Waits for every predicted event, then lets the pipeline settle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly wheel sweeps in one direction with random content, with button
  // presses, empty words and fully random words mixed in.
  function automatic logic [15:0] next_status();
    logic [15:0] status;
    int          pick;
    int          seg;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(9) == 0) sweep_fwd = !sweep_fwd;
      case ($urandom_range(9))
        0:       sweep_seg = sweep_seg + 3'd4;
        1:       ;
        default: sweep_seg = sweep_fwd ? sweep_seg + 3'($urandom_range(3, 1))
                                       : sweep_seg - 3'($urandom_range(3, 1));
      endcase
      seg = int'(sweep_seg);
      status = 16'h1 << seg;
      if ($urandom_range(2) == 0) status |= 16'($urandom) & (status - 16'h1);
    end else if (pick < 78) begin
      status = 16'h0100 | (16'($urandom) & 16'h00FF);
    end else if (pick < 84) begin
      status = 16'h0200 | (16'($urandom) & 16'h01FF);
    end else if (pick < 90) begin
      status = 16'h0000;
    end else begin
      status = 16'($urandom);
    end
    if (pick < 90 && $urandom_range(2) == 0) status |= 16'($urandom) & ~KEY_MASK;
    return status;
  endfunction

  task automatic run_setting(logic [2:0] mode, logic [8:0] lim, logic [8:0] scry,
                             int idle, int stall, int items, bit long_hold);
    write_reg(CFG_WHEEL_MODE, {6'($urandom_range(63)), mode});
    write_reg(CFG_COUNT_LIMIT, lim);
    write_reg(CFG_SCRY_CLEARS, scry | 9'({$urandom_range(255), 1'b0}));
    cfg_we        <= 1'b0;
    send_idle_pct = idle;
    stall_pct     = stall;
    if (long_hold) hold_req = 1'b1;
    for (int n = 0; n < items; n++) begin
      send_status(next_status());
      idle_gap();
    end
    in_valid <= 1'b0;
    drain();
  endtask

  // Directed words: empty status, wheel steps forward, backward and by half a turn,
  // buttons, bits above the key range, and several keys at once.
  logic [15:0] directed_words[20] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h0008, 16'h0080, 16'h0010, 16'h0001,
    16'h0080, 16'h0040, 16'h0100, 16'h0200, 16'h0400, 16'hFC00, 16'h0004,
    16'hFFFF, 16'h0300, 16'h8001, 16'h0180, 16'h00FF, 16'h0000
  };

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: wrap mode, full limit, scry clears.
    foreach (directed_words[k]) send_status(directed_words[k]);
    in_valid <= 1'b0;
    drain();

    // A spare register index must leave the settings alone.
    write_reg(CFG_SPARE, 9'h1FF);

    run_setting(MODE_WRAP,    9'd256, 9'd1,  0,  0, 40, 1'b0);
    run_setting(MODE_BOUNDED, 9'd5,   9'd0, 85,  0, 36, 1'b0);
    run_setting(MODE_BOUNDED, 9'd0,   9'd1,  0, 85, 36, 1'b0);
    run_setting(MODE_ONEHOT,  9'd256, 9'd1, 12, 12, 36, 1'b0);
    run_setting(MODE_ONEHOT,  9'd3,   9'd0,  0,  0, 40, 1'b1);
    run_setting(MODE_ABS,     9'd511, 9'd1, 85,  0, 36, 1'b0);
    run_setting(MODE_IGNORE,  9'd1,   9'd0,  0, 85, 36, 1'b0);
    run_setting(3'd7,         9'd300, 9'd1, 12, 12, 30, 1'b0);
    run_setting(MODE_WRAP,    9'd8,   9'd0, 12, 12, 36, 1'b0);
    run_setting(3'd5,         9'd2,   9'd1,  0,  0, 20, 1'b0);
    run_setting(MODE_BOUNDED, 9'd256, 9'd1,  0,  0, 40, 1'b0);
    run_setting(3'd6,         9'd9,   9'd0, 85, 85, 20, 1'b0);
    run_setting(MODE_ONEHOT,  9'd8,   9'd1,  0,  0, 30, 1'b0);

    if (sb.faults == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/twsc_pkg.sv
sv/twsc_decode.sv
sv/touch_wheel_step_counter.sv
tb/touch_wheel_step_counter_test.sv
